/* hdl/bcil_pkg.sv */
// Shared types, constants and codes for the bounded compacting id list.
package bcil_pkg;

   localparam int CAPACITY     = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int STORE_BITS   = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      FUNC_APPEND   = 2'd0,
      FUNC_DEL_ID   = 2'd1,
      FUNC_DEL_LAST = 2'd2,
      FUNC_FIND     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_POP
   } state_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] item_id;
      logic [31:0]        item_payload;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         found_index;
      logic signed [31:0] out_id;
      logic [31:0]        out_payload;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0]           id;
      logic [STORE_BITS-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

endpackage

/* hdl/bcil_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module bcil_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bcil_ctrl.sv */
// Request sequencer: search, compaction shift, count and result register.
module bcil_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bcil_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output bcil_pkg::rsp_type   rsp_data,
   output bcil_pkg::ram_wr_type ram_wr,
   output bcil_pkg::ram_rd_type ram_rd,
   input  bcil_pkg::entry_type ram_rd_data
);

   bcil_pkg::state_type state_ff, state_in;
   logic [bcil_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [bcil_pkg::CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic chk_vld_ff, chk_vld_in;
   logic [bcil_pkg::IDX_W-1:0] chk_ptr_ff, chk_ptr_in;
   bcil_pkg::func_type func_ff, func_in;
   logic [31:0] id_ff, id_in;
   logic [bcil_pkg::IDX_W-1:0] hit_idx_ff, hit_idx_in;
   bcil_pkg::entry_type hit_data_ff, hit_data_in;
   bcil_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_vld_ff, rsp_vld_in;

   function automatic bcil_pkg::rsp_type make_rsp(
      input bcil_pkg::status_type      status,
      input logic [bcil_pkg::IDX_W-1:0] idx,
      input bcil_pkg::entry_type        entry,
      input logic [bcil_pkg::CNT_W-1:0] count
   );
      bcil_pkg::rsp_type r;
      r.status      = status;
      r.found_index = 4'(idx);
      r.out_id      = entry.id;
      r.out_payload = 32'(entry.payload);
      r.entry_count = 5'(count);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bcil_pkg::S_IDLE;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rd_ptr_ff   <= rd_ptr_in;
      chk_ptr_ff  <= chk_ptr_in;
      func_ff     <= func_in;
      id_ff       <= id_in;
      hit_idx_ff  <= hit_idx_in;
      hit_data_ff <= hit_data_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      logic [bcil_pkg::CNT_W-1:0] cnt_inc;
      logic [bcil_pkg::CNT_W-1:0] cnt_dec;
      logic                       issue;
      bcil_pkg::entry_type        new_entry;

      cnt_inc = cnt_ff + 1'b1;
      cnt_dec = cnt_ff - 1'b1;
      issue   = (rd_ptr_ff < cnt_ff);
      new_entry.id      = req_data.item_id;
      new_entry.payload = req_data.item_payload[bcil_pkg::STORE_BITS-1:0];

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rd_ptr_in   = rd_ptr_ff;
      chk_vld_in  = chk_vld_ff;
      chk_ptr_in  = chk_ptr_ff;
      func_in     = func_ff;
      id_in       = id_ff;
      hit_idx_in  = hit_idx_ff;
      hit_data_in = hit_data_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;
      ram_wr      = '0;
      ram_rd      = '0;
      busy        = (state_ff != bcil_pkg::S_IDLE);

      unique case (state_ff)
         bcil_pkg::S_IDLE: begin
            if (start) begin
               func_in = req_data.func;
               id_in   = req_data.item_id;
               unique case (req_data.func)
                  bcil_pkg::FUNC_APPEND: begin
                     rsp_vld_in = 1'b1;
                     if (cnt_ff == bcil_pkg::CNT_W'(bcil_pkg::CAPACITY)) begin
                        rsp_in = make_rsp(bcil_pkg::STAT_FULL, '0, '0, cnt_ff);
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = bcil_pkg::IDX_W'(cnt_ff);
                        ram_wr.data = new_entry;
                        cnt_in      = cnt_inc;
                        rsp_in      = make_rsp(bcil_pkg::STAT_OK, '0, '0, cnt_inc);
                     end
                  end
                  bcil_pkg::FUNC_DEL_ID, bcil_pkg::FUNC_FIND: begin
                     if (cnt_ff == '0) begin
                        rsp_vld_in = 1'b1;
                        rsp_in = make_rsp((req_data.func == bcil_pkg::FUNC_DEL_ID) ?
                                          bcil_pkg::STAT_EMPTY : bcil_pkg::STAT_NOT_FOUND,
                                          '0, '0, cnt_ff);
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = '0;
                        chk_vld_in  = 1'b1;
                        chk_ptr_in  = '0;
                        rd_ptr_in   = bcil_pkg::CNT_W'(1);
                        state_in    = bcil_pkg::S_SEARCH;
                     end
                  end
                  bcil_pkg::FUNC_DEL_LAST: begin
                     if (cnt_ff == '0) begin
                        rsp_vld_in = 1'b1;
                        rsp_in = make_rsp(bcil_pkg::STAT_EMPTY, '0, '0, cnt_ff);
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = bcil_pkg::IDX_W'(cnt_dec);
                        state_in    = bcil_pkg::S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bcil_pkg::S_SEARCH: begin
            ram_rd.en   = issue;
            ram_rd.addr = bcil_pkg::IDX_W'(rd_ptr_ff);
            chk_vld_in  = issue;
            chk_ptr_in  = bcil_pkg::IDX_W'(rd_ptr_ff);
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            priority if (chk_vld_ff && (ram_rd_data.id == id_ff)) begin
               if (func_ff == bcil_pkg::FUNC_FIND) begin
                  rsp_vld_in = 1'b1;
                  rsp_in     = make_rsp(bcil_pkg::STAT_OK, chk_ptr_ff, '0, cnt_ff);
                  state_in   = bcil_pkg::S_IDLE;
               end else begin
                  hit_idx_in  = chk_ptr_ff;
                  hit_data_in = ram_rd_data;
                  state_in    = bcil_pkg::S_SHIFT;
               end
            end else if (!chk_vld_ff) begin
               rsp_vld_in = 1'b1;
               rsp_in     = make_rsp(bcil_pkg::STAT_NOT_FOUND, '0, '0, cnt_ff);
               state_in   = bcil_pkg::S_IDLE;
            end else begin
            end
         end
         bcil_pkg::S_SHIFT: begin
            if (chk_vld_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = chk_ptr_ff - 1'b1;
               ram_wr.data = ram_rd_data;
               ram_rd.en   = issue;
               ram_rd.addr = bcil_pkg::IDX_W'(rd_ptr_ff);
               chk_vld_in  = issue;
               chk_ptr_in  = bcil_pkg::IDX_W'(rd_ptr_ff);
               if (issue) begin
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end else begin
               cnt_in     = cnt_dec;
               rsp_vld_in = 1'b1;
               rsp_in     = make_rsp(bcil_pkg::STAT_OK, hit_idx_ff, hit_data_ff, cnt_dec);
               state_in   = bcil_pkg::S_IDLE;
            end
         end
         bcil_pkg::S_POP: begin
            cnt_in     = cnt_dec;
            rsp_vld_in = 1'b1;
            rsp_in     = make_rsp(bcil_pkg::STAT_OK, bcil_pkg::IDX_W'(cnt_dec),
                                  ram_rd_data, cnt_dec);
            state_in   = bcil_pkg::S_IDLE;
         end
         default: begin
            state_in = bcil_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* hdl/bounded_compacting_id_list.sv */
// Bounded compacting id list: top level with entry memory and sequencer.
// Append and every error on an empty or full list give the result in the cycle after start.
// Delete last reads the last entry in S_POP, then returns it; find and delete by id make one
// memory read per cycle over the id search, with the shift writes riding the same read stream.
// Requests are taken one at a time, only while idle; busy drops in the strobe cycle, which may accept the next.
// Reset (synchronous, active high) empties the list; memory contents are not cleared.
module bounded_compacting_id_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bcil_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bcil_pkg::rsp_type rsp_data
);

   bcil_pkg::ram_wr_type ram_wr;
   bcil_pkg::ram_rd_type ram_rd;
   bcil_pkg::entry_type  ram_rd_data;

   bcil_ram #(
      .DEPTH (bcil_pkg::CAPACITY),
      .WIDTH ($bits(bcil_pkg::entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rd_data)
   );

   bcil_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == bcil_pkg::STAT_FULL)
      |-> rsp_data.entry_count == 5'(bcil_pkg::CAPACITY))
      else $error("full status with list not at capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == bcil_pkg::STAT_EMPTY)
      |-> rsp_data.entry_count == '0)
      else $error("empty status with entries present");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != bcil_pkg::STAT_OK)
      |-> (rsp_data.found_index == '0) && (rsp_data.out_id == '0)
          && (rsp_data.out_payload == '0))
      else $error("error result carries entry data");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> ram_wr.addr <= bcil_pkg::IDX_W'(bcil_pkg::CAPACITY - 1))
      else $error("memory write beyond capacity");
`endif

endmodule
